// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DFIN,
        S_FIN
    } t_state;

    // item kinds
    localparam logic [1:0] OP_PUSH_VALUE = 2'd0;
    localparam logic [1:0] OP_PUSH_OPER  = 2'd1;
    localparam logic [1:0] OP_CALC       = 2'd2;

    // operator codes
    localparam logic [1:0] OPR_ADD = 2'd0;
    localparam logic [1:0] OPR_SUB = 2'd1;
    localparam logic [1:0] OPR_MUL = 2'd2;
    localparam logic [1:0] OPR_DIV = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_VFULL = 3'd1;
    localparam logic [2:0] ST_OFULL = 3'd2;
    localparam logic [2:0] ST_FEW   = 3'd3;
    localparam logic [2:0] ST_DIVZ  = 3'd4;

    // q16.16 saturation limits
    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // quotient bits produced by the divider, one per cycle
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage

// ===== rtl/two_stack_calculator.sv =====
// pushes and rejected items answer in the cycle after the transfer; pushes go one per cycle
// while the output is free, none during a calculation; the 34-bit adder/subtractor is shared
// add/subtract run S_EXEC, S_FIN; multiply S_EXEC, S_MUL, S_FIN; divide S_EXEC, S_DIV (32
// quotient bits, one per cycle), S_DFIN, S_FIN, or S_EXEC, S_FIN on a zero divisor or a
// quotient past 32 bits; S_FIN waits for a free output; the stacks are single-port memories
// reset (synchronous, active low) empties both stacks and drops any pending result
module two_stack_calculator
    import tsc_pkg::*;
#(
    parameter int VALUE_DEPTH    = 32,
    parameter int OPERATOR_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_value_in,
    input  logic [1:0]         i_operator_code,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_top_value,
    output logic [5:0]         o_value_count,
    output logic [5:0]         o_operator_count
);

    localparam int VAW = $clog2(VALUE_DEPTH);
    localparam int VCW = $clog2(VALUE_DEPTH + 1);
    localparam int OAW = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;
    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);

    // control registers
    t_state           r_state, n_state;
    logic [VCW-1:0]   r_vdepth, n_vdepth;
    logic [OCW-1:0]   r_odepth, n_odepth;
    logic             r_ov, n_ov;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // datapath registers
    logic signed [31:0] r_top, n_top;
    logic signed [31:0] r_b;
    logic [1:0]         r_k;
    logic signed [63:0] r_prod, n_prod;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_dq, n_dq;
    logic [31:0]        r_d, n_d;
    logic               r_neg, n_neg;
    logic [31:0]        r_res, n_res;
    logic [2:0]         r_stat, n_stat;

    // output registers
    logic [2:0]  r_o_status;
    logic [31:0] r_o_top;
    logic [5:0]  r_o_vc;
    logic [5:0]  r_o_oc;

    // stacks
    logic [31:0] r_vmem [VALUE_DEPTH];
    logic [1:0]  r_omem [OPERATOR_DEPTH];

    // memory control
    logic           v_we;
    logic [VAW-1:0] v_waddr;
    logic [31:0]    v_wdata;
    logic           o_we;
    logic [OAW-1:0] o_waddr;
    logic           rd_en;
    logic [VAW-1:0] v_raddr;
    logic [OAW-1:0] o_raddr;

    // output load
    logic           ld;
    logic [2:0]     ld_status;
    logic [31:0]    ld_top;
    logic [VCW-1:0] ld_vc;
    logic [OCW-1:0] ld_oc;
    logic [VCW+5:0] ld_vc_ext;
    logic [OCW+5:0] ld_oc_ext;

    // helpers
    logic           in_xfer;
    logic           out_free;
    logic           v_full;
    logic           o_full;
    logic           few;
    logic [VCW-1:0] vd_m1;
    logic [VCW-1:0] vd_m2;
    logic [OCW-1:0] od_m1;
    logic [31:0]    cur_top;

    // shared adder/subtractor
    logic [33:0] alu_x;
    logic [33:0] alu_y;
    logic        alu_sub;
    logic [33:0] alu_out;

    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    logic signed [47:0] mul_sh;
    logic [32:0]        rem_sh;
    logic               borrow;

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;

    assign v_full  = r_vdepth >= VCW'(VALUE_DEPTH);
    assign o_full  = r_odepth >= OCW'(OPERATOR_DEPTH);
    assign few     = (r_vdepth < VCW'(2)) || (r_odepth == '0);
    assign vd_m1   = r_vdepth - VCW'(1);
    assign vd_m2   = r_vdepth - VCW'(2);
    assign od_m1   = r_odepth - OCW'(1);
    assign cur_top = (r_vdepth == '0) ? 32'd0 : r_top;
    assign v_raddr = vd_m2[VAW-1:0];
    assign o_raddr = od_m1[OAW-1:0];

    // operand magnitudes and products
    assign abs_a  = r_top[31] ? (~r_top + 32'd1) : r_top;
    assign abs_b  = r_b[31] ? (~r_b + 32'd1) : r_b;
    assign mul_sh = r_prod[63:16];
    assign rem_sh = {r_rem, r_dq[31]};

    assign alu_out = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);
    assign borrow  = alu_out[33];

    // shared unit operand select
    always_comb begin
        alu_x   = {{2{r_top[31]}}, r_top};
        alu_y   = {{2{r_b[31]}}, r_b};
        alu_sub = (r_k == OPR_SUB);
        case (r_state)
            S_DIV: begin
                alu_x   = {1'b0, rem_sh};
                alu_y   = {2'b00, r_d};
                alu_sub = 1'b1;
            end
            S_DFIN: begin
                alu_x   = '0;
                alu_y   = {2'b00, r_dq};
                alu_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer: next state, stack updates and result load
    always_comb begin
        n_state   = r_state;
        n_vdepth  = r_vdepth;
        n_odepth  = r_odepth;
        n_cnt     = r_cnt;
        n_top     = r_top;
        n_prod    = r_prod;
        n_rem     = r_rem;
        n_dq      = r_dq;
        n_d       = r_d;
        n_neg     = r_neg;
        n_res     = r_res;
        n_stat    = r_stat;
        v_we      = 1'b0;
        v_waddr   = r_vdepth[VAW-1:0];
        v_wdata   = i_value_in;
        o_we      = 1'b0;
        o_waddr   = r_odepth[OAW-1:0];
        rd_en     = 1'b0;
        ld        = 1'b0;
        ld_status = ST_OK;
        ld_top    = cur_top;
        ld_vc     = r_vdepth;
        ld_oc     = r_odepth;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    ld = 1'b1;
                    case (i_op)
                        OP_PUSH_VALUE: begin
                            if (v_full) begin
                                ld_status = ST_VFULL;
                            end else begin
                                v_we     = 1'b1;
                                n_vdepth = r_vdepth + VCW'(1);
                                n_top    = i_value_in;
                                ld_top   = i_value_in;
                                ld_vc    = r_vdepth + VCW'(1);
                            end
                        end
                        OP_PUSH_OPER: begin
                            if (o_full) begin
                                ld_status = ST_OFULL;
                            end else begin
                                o_we     = 1'b1;
                                n_odepth = r_odepth + OCW'(1);
                                ld_oc    = r_odepth + OCW'(1);
                            end
                        end
                        OP_CALC: begin
                            if (few) begin
                                ld_status = ST_FEW;
                            end else begin
                                ld      = 1'b0;
                                rd_en   = 1'b1;
                                n_state = S_EXEC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_stat = ST_OK;
                case (r_k)
                    OPR_ADD, OPR_SUB: begin
                        if (alu_out[32] != alu_out[31]) begin
                            n_res = alu_out[32] ? Q_MIN : Q_MAX;
                        end else begin
                            n_res = alu_out[31:0];
                        end
                        n_state = S_FIN;
                    end
                    OPR_MUL: begin
                        n_prod  = r_top * r_b;
                        n_state = S_MUL;
                    end
                    default: begin
                        n_neg = r_top[31] ^ r_b[31];
                        n_d   = abs_b;
                        n_rem = {16'd0, abs_a[31:16]};
                        n_dq  = {abs_a[15:0], 16'd0};
                        n_cnt = '0;
                        if (r_b == '0) begin
                            n_stat  = ST_DIVZ;
                            n_res   = r_top[31] ? Q_MIN : Q_MAX;
                            n_state = S_FIN;
                        end else if (abs_b <= {16'd0, abs_a[31:16]}) begin
                            // quotient needs more than 32 bits
                            n_res   = (r_top[31] ^ r_b[31]) ? Q_MIN : Q_MAX;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                if ((&mul_sh[47:31]) || !(|mul_sh[47:31])) begin
                    n_res = mul_sh[31:0];
                end else begin
                    n_res = mul_sh[47] ? Q_MIN : Q_MAX;
                end
                n_state = S_FIN;
            end
            S_DIV: begin
                // restoring step: one quotient bit per cycle
                n_rem = borrow ? rem_sh[31:0] : alu_out[31:0];
                n_dq  = {r_dq[30:0], ~borrow};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                if (r_neg) begin
                    n_res = r_dq[31] ? Q_MIN : alu_out[31:0];
                end else begin
                    n_res = r_dq[31] ? Q_MAX : r_dq;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_status = r_stat;
                    ld_top    = r_res;
                    ld_vc     = vd_m1;
                    ld_oc     = od_m1;
                    v_we      = 1'b1;
                    v_waddr   = vd_m2[VAW-1:0];
                    v_wdata   = r_res;
                    n_vdepth  = vd_m1;
                    n_odepth  = od_m1;
                    n_top     = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ov = ld ? 1'b1 : (r_ov && !i_ready);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vdepth <= '0;
            r_odepth <= '0;
            r_ov     <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_vdepth <= n_vdepth;
            r_odepth <= n_odepth;
            r_ov     <= n_ov;
            r_cnt    <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_dq   <= n_dq;
        r_d    <= n_d;
        r_neg  <= n_neg;
        r_res  <= n_res;
        r_stat <= n_stat;
    end

    // result register
    assign ld_vc_ext = {6'd0, ld_vc};
    assign ld_oc_ext = {6'd0, ld_oc};

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_o_status <= ld_status;
            r_o_top    <= ld_top;
            r_o_vc     <= ld_vc_ext[5:0];
            r_o_oc     <= ld_oc_ext[5:0];
        end
    end

    // value stack
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[v_waddr] <= v_wdata;
        end
        if (rd_en) begin
            r_b <= r_vmem[v_raddr];
        end
    end

    // operator stack
    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_omem[o_waddr] <= i_operator_code;
        end
        if (rd_en) begin
            r_k <= r_omem[o_raddr];
        end
    end

    assign o_valid          = r_ov;
    assign o_status         = r_o_status;
    assign o_top_value      = r_o_top;
    assign o_value_count    = r_o_vc;
    assign o_operator_count = r_o_oc;

    // value stack depth stays within its bound
    a_vdepth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vdepth <= VCW'(VALUE_DEPTH))
        else $error("value stack depth past its bound");

    // a calculate with enough operands starts the sequencer
    a_calc_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_op == OP_CALC && !few) |=> (r_state == S_EXEC))
        else $error("calculate transfer did not start the sequencer");

    // divider leaves after exactly its step count
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_DFIN))
        else $error("divider did not finish on its last step");

    // divide by zero always reports a saturated value
    a_divz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DIVZ) |-> (o_top_value == Q_MAX || o_top_value == Q_MIN))
        else $error("divide by zero result not saturated");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import tsc_pkg::*;

    localparam int VAL_DEPTH   = 32;
    localparam int OPR_DEPTH   = 32;
    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [1:0]         code;
    } t_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] top;
        logic [5:0]         vcount;
        logic [5:0]         ocount;
    } t_result;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_ready;
    logic [1:0]         i_op            = '0;
    logic signed [31:0] i_value_in      = '0;
    logic [1:0]         i_operator_code = '0;
    logic               o_valid;
    logic               i_ready         = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_top_value;
    logic [5:0]         o_value_count;
    logic [5:0]         o_operator_count;

    // pending stimulus and expected results
    t_item   pend_items[$];
    t_result exp_results[$];

    // predictor copy of both stacks
    logic signed [31:0] val_stack [VAL_DEPTH];
    logic [1:0]         opr_stack [OPR_DEPTH];
    int                 val_depth = 0;
    int                 opr_depth = 0;

    // depth estimate used only while building stimulus
    int gen_vals = 0;
    int gen_ops  = 0;

    logic in_taken = 1'b0;
    int   tx_gap = 0, tx_calm = 0, rx_stall = 0, rx_calm = 0;
    int   fail_count = 0, items_taken = 0, results_seen = 0, cycle_count = 0;
    int   status_hits [8];

    two_stack_calculator #(
        .VALUE_DEPTH   (VAL_DEPTH),
        .OPERATOR_DEPTH(OPR_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_value_in      (i_value_in),
        .i_operator_code (i_operator_code),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_top_value     (o_top_value),
        .o_value_count   (o_value_count),
        .o_operator_count(o_operator_count)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // saturate to the q16.16 range
    function automatic logic signed [31:0] clamp(longint v);
        if (v > 64'sd2147483647) return Q_MAX;
        if (v < -64'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    // apply one item to the predicted stacks and return the expected answer
    function automatic t_result stack_step(t_item it);
        t_result            r;
        longint             a, b;
        logic [1:0]         k;
        logic signed [31:0] q;
        r.status = ST_OK;
        case (it.op)
            OP_PUSH_VALUE: begin
                if (val_depth >= VAL_DEPTH) begin
                    r.status = ST_VFULL;
                end else begin
                    val_stack[val_depth] = it.value;
                    val_depth++;
                end
            end
            OP_PUSH_OPER: begin
                if (opr_depth >= OPR_DEPTH) begin
                    r.status = ST_OFULL;
                end else begin
                    opr_stack[opr_depth] = it.code;
                    opr_depth++;
                end
            end
            OP_CALC: begin
                if (val_depth < 2 || opr_depth < 1) begin
                    r.status = ST_FEW;
                end else begin
                    // top value is the left operand
                    a = val_stack[val_depth - 1];
                    b = val_stack[val_depth - 2];
                    k = opr_stack[opr_depth - 1];
                    val_depth -= 2;
                    opr_depth--;
                    case (k)
                        OPR_ADD: q = clamp(a + b);
                        OPR_SUB: q = clamp(a - b);
                        OPR_MUL: q = clamp((a * b) >>> 16);
                        default: begin
                            if (b == 0) begin
                                r.status = ST_DIVZ;
                                q = (a < 0) ? Q_MIN : Q_MAX;
                            end else begin
                                q = clamp((a * 65536) / b);
                            end
                        end
                    endcase
                    val_stack[val_depth] = q;
                    val_depth++;
                end
            end
            default: ;
        endcase
        r.top    = (val_depth > 0) ? val_stack[val_depth - 1] : 32'sd0;
        r.vcount = 6'(val_depth);
        r.ocount = 6'(opr_depth);
        return r;
    endfunction

    // operand mix: raw bits, moderate, small and the corner values
    function automatic logic signed [31:0] rand_q();
        int unsigned pick;
        logic [31:0] raw;
        pick = $urandom_range(0, 99);
        raw  = $urandom;
        if (pick < 25) return raw;
        if (pick < 55) return $signed(raw) >>> $urandom_range(8, 20);
        if (pick < 80) return {{13{raw[31]}}, raw[18:0]};
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'sd0;
            3: return 32'sh0001_0000;
            4: return 32'shffff_0000;
            5: return 32'sd1;
            6: return -32'sd1;
            default: return 32'sh0000_8000;
        endcase
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_item(logic [1:0] op, logic signed [31:0] value, logic [1:0] code);
        t_item it;
        it.op    = op;
        it.value = value;
        it.code  = code;
        pend_items.push_back(it);
        case (op)
            OP_PUSH_VALUE: if (gen_vals < VAL_DEPTH) gen_vals++;
            OP_PUSH_OPER:  if (gen_ops < OPR_DEPTH) gen_ops++;
            OP_CALC: begin
                if (gen_vals >= 2 && gen_ops >= 1) begin
                    gen_vals--;
                    gen_ops--;
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_value();
        add_item(OP_PUSH_VALUE, rand_q(), 2'($urandom_range(0, 3)));
    endtask

    task automatic add_oper();
        add_item(OP_PUSH_OPER, $urandom, 2'($urandom_range(0, 3)));
    endtask

    task automatic add_calc();
        add_item(OP_CALC, $urandom, 2'($urandom_range(0, 3)));
    endtask

    // input side: present queued items, with gaps after transfers
    always @(negedge i_clk) begin : driver
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (tx_gap > 0) begin
                i_valid <= 1'b0;
                tx_gap--;
            end else if (pend_items.size() > 0) begin
                nxt = pend_items.pop_front();
                i_valid         <= 1'b1;
                i_op            <= nxt.op;
                i_value_in      <= nxt.value;
                i_operator_code <= nxt.code;
                if (tx_calm > 0) begin
                    tx_calm--;
                    tx_gap = 0;
                end else begin
                    tx_gap = idle_len();
                    if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 120);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side: random back-pressure with quiet stretches
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            i_ready <= 1'b0;
            rx_stall--;
        end else if (rx_calm > 0) begin
            i_ready <= 1'b1;
            rx_calm--;
        end else begin
            if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 120);
            rx_stall = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
            i_ready <= (rx_stall == 0);
            if (rx_stall > 0) rx_stall--;
        end
    end

    // check result transfers, then predict on input transfers
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_item   got;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (exp_results.size() == 0) begin
                    $error("result transfer with nothing expected (status %0d)", o_status);
                    fail_count++;
                end else begin
                    want = exp_results.pop_front();
                    results_seen++;
                    status_hits[want.status]++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_top_value !== want.top) begin
                        $error("top_value: expected %0d, got %0d", want.top, o_top_value);
                        fail_count++;
                    end
                    if (o_value_count !== want.vcount) begin
                        $error("value_count: expected %0d, got %0d",
                               want.vcount, o_value_count);
                        fail_count++;
                    end
                    if (o_operator_count !== want.ocount) begin
                        $error("operator_count: expected %0d, got %0d",
                               want.ocount, o_operator_count);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                got.op    = i_op;
                got.value = i_value_in;
                got.code  = i_operator_code;
                exp_results.push_back(stack_step(got));
                items_taken++;
            end
            in_taken <= i_valid && o_ready;
        end
    end

    // run limit
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // reset
    initial begin : reset_seq
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stimulus build and end of run
    initial begin : sequencer
        int unsigned pick;
        int          n;
        for (int s = 0; s < 8; s++) status_hits[s] = 0;

        // directed: empty stack, unused op, saturating corners, divide by zero
        add_calc();
        add_item(2'd3, $urandom, 2'($urandom_range(0, 3)));
        add_item(OP_PUSH_OPER, 32'sd0, OPR_ADD);
        add_calc();
        add_item(OP_PUSH_VALUE, Q_MAX, 2'd0);
        add_item(OP_PUSH_VALUE, 32'sd1, 2'd3);
        add_calc();
        add_item(OP_PUSH_VALUE, Q_MIN, 2'd1);
        add_item(OP_PUSH_OPER, -32'sd1, OPR_SUB);
        add_calc();
        add_item(OP_PUSH_VALUE, -32'sd1, 2'd2);
        add_item(OP_PUSH_OPER, Q_MAX, OPR_MUL);
        add_calc();
        // divisor zero with a negative dividend
        add_item(OP_PUSH_VALUE, 32'sd0, 2'd0);
        add_item(OP_PUSH_VALUE, 32'shffff_0000, 2'd0);
        add_item(OP_PUSH_OPER, 32'sd0, OPR_DIV);
        add_calc();
        // quotient overflow
        add_item(OP_PUSH_OPER, 32'sd0, OPR_DIV);
        add_calc();
        // zero over zero
        add_item(OP_PUSH_VALUE, 32'sd0, 2'd0);
        add_item(OP_PUSH_VALUE, 32'sd0, 2'd0);
        add_item(OP_PUSH_OPER, 32'sd0, OPR_DIV);
        add_calc();
        add_item(OP_PUSH_OPER, 32'sd0, OPR_MUL);
        add_calc();

        // random sequences, steered by the estimated stack depths
        while (pend_items.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (gen_vals > 26 || gen_ops > 26) pick = 80;
            if (pick < 45) begin
                // one binary operation, sometimes with a zero divisor
                add_item(OP_PUSH_VALUE, ($urandom_range(0, 19) == 0) ? 32'sd0 : rand_q(),
                         2'($urandom_range(0, 3)));
                add_value();
                add_oper();
                add_calc();
            end else if (pick < 60) begin
                // nested expression
                n = $urandom_range(2, 6);
                add_value();
                repeat (n) begin
                    add_value();
                    add_oper();
                end
                repeat (n) add_calc();
            end else if (pick < 66) begin
                // fill the value stack past full
                repeat (VAL_DEPTH - gen_vals + $urandom_range(1, 3)) add_value();
            end else if (pick < 71) begin
                // fill the operator stack past full
                repeat (OPR_DEPTH - gen_ops + $urandom_range(1, 3)) add_oper();
            end else if (pick < 90) begin
                // pull the stacks back down
                n = $urandom_range(1, 12);
                repeat (n) begin
                    if (gen_vals < 2) add_value();
                    if (gen_ops > 0 && $urandom_range(0, 1) == 1) begin
                        add_calc();
                    end else begin
                        add_oper();
                        add_calc();
                    end
                end
            end else begin
                // noise
                repeat ($urandom_range(1, 6))
                    add_item(2'($urandom_range(0, 3)), $urandom, 2'($urandom_range(0, 3)));
            end
        end

        while (pend_items.size() != 0 || i_valid || exp_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d item transfers and %0d checked results in %0d cycles",
                 items_taken, results_seen, cycle_count);
        $display("outcomes: %0d value full, %0d operator full, %0d short of operands, %0d div by zero",
                 status_hits[ST_VFULL], status_hits[ST_OFULL], status_hits[ST_FEW],
                 status_hits[ST_DIVZ]);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tsc_pkg.sv
rtl/two_stack_calculator.sv
dv/tb.sv
